// ----- rtl/lbpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lbpt_pkg;

  localparam int SLOTS   = 16;
  localparam int ID_BITS = 32;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int CAP_W   = 5;
  localparam int EC_W    = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic update;
  } lbpt_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/lbpt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lbpt_ctrl
  import lbpt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output lbpt_cmd_t      cmd,
  output logic           busy
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.lookup  = 1'b0;
    cmd.update  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

// ----- rtl/lbpt_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lbpt_dp
  import lbpt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lbpt_cmd_t          cmd,
  input  wire logic               in_opcode,
  input  wire logic [ID_BITS-1:0] in_block_id,
  input  wire logic               in_modified,
  input  wire logic               cfg_wr_en,
  input  wire logic [CAP_W-1:0]   cfg_wr_data,
  output logic                    out_strobe,
  output logic                    out_hit,
  output logic [SLOT_W-1:0]       out_slot,
  output logic                    out_fetch_needed,
  output logic                    out_evicted_valid,
  output logic [ID_BITS-1:0]      out_evicted_id,
  output logic                    out_writeback_needed
);

  // tag store
  logic [SLOTS-1:0]   valid_r;
  logic [ID_BITS-1:0] tag_r   [SLOTS];
  logic [SLOTS-1:0]   dirty_r;
  logic [SLOT_W-1:0]  age_r   [SLOTS];
  logic [CNT_W-1:0]   occ_r;
  logic [CAP_W-1:0]   cap_r;

  // captured request
  logic               req_op_r;
  logic [ID_BITS-1:0] req_id_r;
  logic               req_mod_r;

  // lookup results
  logic               lk_hit_r;
  logic               lk_evict_r;
  logic [SLOT_W-1:0]  lk_hit_idx_r;
  logic [SLOT_W-1:0]  lk_vict_idx_r;
  logic [SLOT_W-1:0]  lk_free_idx_r;

  // lookup logic
  logic               hit;
  logic [SLOT_W-1:0]  hit_idx;
  logic [SLOT_W-1:0]  vict_idx;
  logic [SLOT_W-1:0]  free_idx;
  logic [CNT_W-1:0]   occ_m1;
  logic [EC_W-1:0]    cap_ext;
  logic [EC_W-1:0]    eff_cap;
  logic               evict_need;

  // valid ages always form 0..occ-1, so the oldest entry has age occ-1
  assign occ_m1 = occ_r - CNT_W'(1);

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    vict_idx = '0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (valid_r[i] && (tag_r[i] == req_id_r)) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (valid_r[i] && (age_r[i] == occ_m1[SLOT_W-1:0])) begin
        vict_idx = SLOT_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    cap_ext = EC_W'(cap_r);
    if (cap_ext == '0) begin
      eff_cap = EC_W'(1);
    end else if (cap_ext > EC_W'(SLOTS)) begin
      eff_cap = EC_W'(SLOTS);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign evict_need = !hit && (EC_W'(occ_r) >= eff_cap);

  // update logic
  logic [SLOT_W-1:0] upd_slot;
  logic [SLOT_W-1:0] upd_age;
  logic              touch;
  logic [SLOTS-1:0]  age_inc;

  always_comb begin
    if (lk_hit_r) begin
      upd_slot = lk_hit_idx_r;
    end else if (lk_evict_r) begin
      upd_slot = lk_vict_idx_r;
    end else begin
      upd_slot = lk_free_idx_r;
    end
    upd_age = age_r[upd_slot];
    touch   = lk_hit_r && (req_op_r == OP_GET);
    for (int i = 0; i < SLOTS; i++) begin
      age_inc[i] = valid_r[i] && (SLOT_W'(i) != upd_slot) &&
                   ((!lk_hit_r) || (touch && (age_r[i] < upd_age)));
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      occ_r      <= '0;
      cap_r      <= CAP_RESET;
      out_strobe <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (cmd.update && !lk_hit_r) begin
        valid_r[upd_slot] <= 1'b1;
        if (!lk_evict_r) begin
          occ_r <= occ_r + CNT_W'(1);
        end
      end
      out_strobe <= cmd.update;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op_r  <= in_opcode;
      req_id_r  <= in_block_id;
      req_mod_r <= in_modified;
    end
    if (cmd.lookup) begin
      lk_hit_r      <= hit;
      lk_evict_r    <= evict_need;
      lk_hit_idx_r  <= hit_idx;
      lk_vict_idx_r <= vict_idx;
      lk_free_idx_r <= free_idx;
    end
    if (cmd.update) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (age_inc[i]) begin
          age_r[i] <= age_r[i] + SLOT_W'(1);
        end
      end
      if (lk_hit_r) begin
        if (req_op_r == OP_PUT) begin
          dirty_r[upd_slot] <= req_mod_r;
        end else begin
          age_r[upd_slot] <= '0;
        end
      end else begin
        tag_r[upd_slot]   <= req_id_r;
        dirty_r[upd_slot] <= (req_op_r == OP_PUT) && req_mod_r;
        age_r[upd_slot]   <= '0;
      end
      out_hit              <= lk_hit_r;
      out_slot             <= upd_slot;
      out_fetch_needed     <= !lk_hit_r && (req_op_r == OP_GET);
      out_evicted_valid    <= lk_evict_r;
      out_evicted_id       <= lk_evict_r ? tag_r[lk_vict_idx_r] : '0;
      out_writeback_needed <= lk_evict_r && dirty_r[lk_vict_idx_r];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lru_buffer_pool_tags.sv -----
// result strobe follows the start transfer through the capture, lookup and update steps
// one request at a time; start is taken again while the last result is shown
// lookup compares all slots at once; the update cycle writes tag store and result register
// reset: synchronous, active low; pool empty, capacity 16, no clearing pass
// the receiver cannot stall: each result is shown for exactly one cycle
`timescale 1ns / 1ps
`default_nettype none

module lru_buffer_pool_tags
  import lbpt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_opcode,
  input  wire logic [ID_BITS-1:0] in_block_id,
  input  wire logic               in_modified,
  input  wire logic               cfg_wr_en,
  input  wire logic [CAP_W-1:0]   cfg_wr_data,
  output logic                    out_strobe,
  output logic                    out_hit,
  output logic [SLOT_W-1:0]       out_slot,
  output logic                    out_fetch_needed,
  output logic                    out_evicted_valid,
  output logic [ID_BITS-1:0]      out_evicted_id,
  output logic                    out_writeback_needed
);

  lbpt_cmd_t cmd;

  lbpt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .cmd   (cmd),
    .busy  (busy)
  );

  lbpt_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_opcode            (in_opcode),
    .in_block_id          (in_block_id),
    .in_modified          (in_modified),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .out_strobe           (out_strobe),
    .out_hit              (out_hit),
    .out_slot             (out_slot),
    .out_fetch_needed     (out_fetch_needed),
    .out_evicted_valid    (out_evicted_valid),
    .out_evicted_id       (out_evicted_id),
    .out_writeback_needed (out_writeback_needed)
  );

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import lbpt_pkg::*;

  typedef struct packed {
    logic               opcode;
    logic [ID_BITS-1:0] block_id;
    logic               modified;
  } pool_req_t;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               fetch_needed;
    logic               evicted_valid;
    logic [ID_BITS-1:0] evicted_id;
    logic               writeback_needed;
  } pool_outcome_t;

  localparam int IDLE_LIMIT = 1000;
  localparam int ID_TABLE_N = 24;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_opcode = OP_GET;
  logic [ID_BITS-1:0] in_block_id = '0;
  logic               in_modified = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]   cfg_wr_data = '0;
  logic               out_strobe;
  logic               out_hit;
  logic [SLOT_W-1:0]  out_slot;
  logic               out_fetch_needed;
  logic               out_evicted_valid;
  logic [ID_BITS-1:0] out_evicted_id;
  logic               out_writeback_needed;

  lru_buffer_pool_tags dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_opcode            (in_opcode),
    .in_block_id          (in_block_id),
    .in_modified          (in_modified),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .out_strobe           (out_strobe),
    .out_hit              (out_hit),
    .out_slot             (out_slot),
    .out_fetch_needed     (out_fetch_needed),
    .out_evicted_valid    (out_evicted_valid),
    .out_evicted_id       (out_evicted_id),
    .out_writeback_needed (out_writeback_needed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the tag store
  logic               pool_valid [SLOTS];
  logic [ID_BITS-1:0] pool_tag   [SLOTS];
  logic               pool_dirty [SLOTS];
  int                 pool_age   [SLOTS];
  int                 pool_count = 0;
  logic [CAP_W-1:0]   pool_cap = CAP_RESET;

  pool_req_t     req_queue[$];
  pool_outcome_t lookup_outcomes[$];
  logic [ID_BITS-1:0] id_table [ID_TABLE_N];

  int mismatches = 0;
  int reqs_done = 0;
  int hits_seen = 0;
  int fetches_seen = 0;
  int evictions_seen = 0;
  int writebacks_seen = 0;
  int cap_writes = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      pool_valid[i] = 1'b0;
      pool_tag[i]   = '0;
      pool_dirty[i] = 1'b0;
      pool_age[i]   = 0;
    end
  end

  function automatic int active_ways(input logic [CAP_W-1:0] cap);
    if (cap == 0) return 1;
    if (cap > SLOTS) return SLOTS;
    return int'(cap);
  endfunction

  function automatic pool_outcome_t pool_access(input pool_req_t req);
    pool_outcome_t res;
    int s;
    int victim;
    int a;
    res = '0;
    s = -1;
    for (int i = 0; i < SLOTS; i++)
      if (s < 0 && pool_valid[i] && pool_tag[i] == req.block_id) s = i;
    if (s >= 0) begin
      res.hit = 1'b1;
      if (req.opcode == OP_PUT) begin
        pool_dirty[s] = req.modified;
      end else begin
        a = pool_age[s];
        for (int i = 0; i < SLOTS; i++)
          if (pool_valid[i] && i != s && pool_age[i] < a) pool_age[i]++;
        pool_age[s] = 0;
      end
    end else begin
      if (pool_count >= active_ways(pool_cap)) begin
        victim = -1;
        for (int i = 0; i < SLOTS; i++)
          if (pool_valid[i] && (victim < 0 || pool_age[i] > pool_age[victim])) victim = i;
        if (victim >= 0) begin
          res.evicted_valid    = 1'b1;
          res.evicted_id       = pool_tag[victim];
          res.writeback_needed = pool_dirty[victim];
          pool_valid[victim]   = 1'b0;
          pool_count--;
          s = victim;
        end
      end
      for (int i = 0; i < SLOTS; i++)
        if (s < 0 && !pool_valid[i]) s = i;
      if (s < 0) s = 0;
      for (int i = 0; i < SLOTS; i++)
        if (pool_valid[i]) pool_age[i]++;
      pool_valid[s] = 1'b1;
      pool_tag[s]   = req.block_id;
      pool_dirty[s] = (req.opcode == OP_PUT) ? req.modified : 1'b0;
      pool_age[s]   = 0;
      pool_count++;
      res.fetch_needed = (req.opcode == OP_GET);
    end
    res.slot = s[SLOT_W-1:0];
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [ID_BITS-1:0] want,
                                      input logic [ID_BITS-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // driver: most gaps short, a few long, with stretches of back-to-back requests
  int  gap_left = 0;
  int  items_sent = 0;

  function automatic int pick_gap(input logic burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  logic burst_mode = 1'b0;

  always @(posedge clk) begin
    pool_req_t req;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // hold the request until it is taken
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left--;
    end else if (req_queue.size() > 0) begin
      req = req_queue.pop_front();
      in_opcode   <= req.opcode;
      in_block_id <= req.block_id;
      in_modified <= req.modified;
      start       <= 1'b1;
      if (items_sent % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      items_sent++;
      gap_left = pick_gap(burst_mode);
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: check results first, then predict for the transfer at this edge
  always @(posedge clk) begin
    pool_outcome_t want;
    pool_req_t     req;
    if (rst_n) begin
      if (out_strobe) begin
        if (lookup_outcomes.size() == 0) begin
          $error("result strobe with no request outstanding");
          mismatches++;
        end else begin
          want = lookup_outcomes.pop_front();
          check_field("hit", ID_BITS'(want.hit), ID_BITS'(out_hit));
          check_field("slot", ID_BITS'(want.slot), ID_BITS'(out_slot));
          check_field("fetch_needed", ID_BITS'(want.fetch_needed),
                      ID_BITS'(out_fetch_needed));
          check_field("evicted_valid", ID_BITS'(want.evicted_valid),
                      ID_BITS'(out_evicted_valid));
          check_field("evicted_id", want.evicted_id, out_evicted_id);
          check_field("writeback_needed", ID_BITS'(want.writeback_needed),
                      ID_BITS'(out_writeback_needed));
        end
      end
      if (start && !busy) begin
        req.opcode   = in_opcode;
        req.block_id = in_block_id;
        req.modified = in_modified;
        want = pool_access(req);
        lookup_outcomes.push_back(want);
        reqs_done++;
        hits_seen       += int'(want.hit);
        fetches_seen    += int'(want.fetch_needed);
        evictions_seen  += int'(want.evicted_valid);
        writebacks_seen += int'(want.writeback_needed);
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic add_request(input logic op, input logic [ID_BITS-1:0] id, input logic md);
    pool_req_t req;
    req.opcode   = op;
    req.block_id = id;
    req.modified = md;
    req_queue.push_back(req);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (req_queue.size() != 0 || start || lookup_outcomes.size() != 0);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    wait_drained();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    pool_cap = value;
    cap_writes++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_phase(input int count, input logic [CAP_W-1:0] cap);
    int ways;
    int r;
    logic [ID_BITS-1:0] id;
    set_capacity(cap);
    ways = active_ways(cap) + $urandom_range(0, 6);
    if (ways > ID_TABLE_N) ways = ID_TABLE_N;
    // keep part of the old working set so resident blocks survive the change
    for (int i = 0; i < ID_TABLE_N; i++)
      if ($urandom_range(0, 1)) id_table[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 4) id = $urandom;
      else if (r == 4) id = '0;
      else if (r == 5) id = '1;
      else id = id_table[$urandom_range(0, ways - 1)];
      add_request(($urandom_range(0, 99) < 60) ? OP_GET : OP_PUT, id,
                  1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [CAP_W-1:0] caps [10];
    caps = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd2, 5'd0, 5'd12, 5'd17, 5'd0, 5'd16};
    caps[8] = CAP_W'($urandom_range(0, 31));
    for (int i = 0; i < ID_TABLE_N; i++) id_table[i] = $urandom;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset capacity: misses, extreme ids, put hits, get hit with modified set
    add_request(OP_GET, 32'h0000_0000, 1'b0);
    add_request(OP_GET, 32'hFFFF_FFFF, 1'b0);
    add_request(OP_PUT, 32'hFFFF_FFFF, 1'b1);
    add_request(OP_PUT, 32'h1234_5678, 1'b1);
    add_request(OP_PUT, 32'hA5A5_A5A5, 1'b0);
    add_request(OP_GET, 32'h0000_0000, 1'b1);
    add_request(OP_PUT, 32'h0000_0000, 1'b1);
    add_request(OP_PUT, 32'h1234_5678, 1'b0);
    add_request(OP_GET, 32'hFFFF_FFFF, 1'b1);

    // capacity below occupancy: each insert evicts one, dirty ones need write-back
    set_capacity(5'd2);
    add_request(OP_GET, 32'hDEAD_BEEF, 1'b0);
    add_request(OP_PUT, 32'h5555_AAAA, 1'b1);
    add_request(OP_GET, 32'h1234_5678, 1'b0);
    add_request(OP_PUT, 32'h0000_0000, 1'b0);
    add_request(OP_GET, 32'h5555_AAAA, 1'b0);
    add_request(OP_PUT, 32'hFFFF_FFFF, 1'b1);

    // zero acts as a single slot
    set_capacity(5'd0);
    add_request(OP_GET, 32'h0000_0001, 1'b0);
    add_request(OP_PUT, 32'h0000_0002, 1'b1);
    add_request(OP_GET, 32'h0000_0001, 1'b0);
    add_request(OP_PUT, 32'h0000_0001, 1'b1);
    add_request(OP_GET, 32'h0000_0003, 1'b0);

    for (int p = 0; p < 10; p++) random_phase(190, caps[p]);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("%0d requests checked: %0d hits, %0d fetches, %0d evictions, %0d write-backs",
             reqs_done, hits_seen, fetches_seen, evictions_seen, writebacks_seen);
    $display("capacity reprogrammed %0d times, values from 0 up to 31", cap_writes);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
